// ===== hw/rtl/ffpa_pkg.sv =====
// Shared types and constants of the first-fit partition allocator.
package ffpa_pkg;

  typedef logic [3:0] upc_t;

  localparam int UPC_DEPTH = 16;

  localparam upc_t S_IDLE     = 4'd0;
  localparam upc_t S_DISPATCH = 4'd1;
  localparam upc_t S_LOAD     = 4'd2;
  localparam upc_t S_ALLOC    = 4'd3;
  localparam upc_t S_FREE     = 4'd4;
  localparam upc_t S_NOP      = 4'd5;
  localparam upc_t S_SCAN_RD  = 4'd6;
  localparam upc_t S_SCAN_CMP = 4'd7;
  localparam upc_t S_GRANT    = 4'd8;
  localparam upc_t S_NOFIT    = 4'd9;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FREE  = 2'd3;

  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_ALLOC = 2'd1;
  localparam logic [1:0] FN_FREE  = 2'd2;

  typedef enum logic [2:0] {
    C_NEXT,
    C_GOTO,
    C_WAIT_IN,
    C_DISPATCH,
    C_PTR_END,
    C_MISS,
    C_WAIT_OUT
  } cond_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_LOAD,
    RES_FREE,
    RES_OK,
    RES_NOFIT,
    RES_GRANT
  } res_t;

  typedef struct packed {
    cond_t cond;
    upc_t  target;
    logic  take;
    logic  ptr_clr;
    logic  ptr_inc;
    logic  mem_rd;
    res_t  res;
  } cw_t;

  typedef struct packed {
    logic       in_fire;
    logic       out_free;
    logic       ptr_end;
    logic       miss;
    logic [1:0] func;
  } flags_t;

endpackage

// ===== hw/rtl/ffpa_ucode_rom.sv =====
// Microprogram table of the allocator sequencer.
module ffpa_ucode_rom (
  input  ffpa_pkg::upc_t upc,
  output ffpa_pkg::cw_t  cw
);

  localparam ffpa_pkg::cw_t ROM [ffpa_pkg::UPC_DEPTH] = '{
    0: '{cond: ffpa_pkg::C_WAIT_IN, target: ffpa_pkg::S_DISPATCH, take: 1'b1,
         ptr_clr: 1'b0, ptr_inc: 1'b0, mem_rd: 1'b0, res: ffpa_pkg::RES_NONE},
    1: '{cond: ffpa_pkg::C_DISPATCH, target: ffpa_pkg::S_LOAD, take: 1'b0,
         ptr_clr: 1'b0, ptr_inc: 1'b0, mem_rd: 1'b0, res: ffpa_pkg::RES_NONE},
    2: '{cond: ffpa_pkg::C_WAIT_OUT, target: ffpa_pkg::S_IDLE, take: 1'b0,
         ptr_clr: 1'b0, ptr_inc: 1'b0, mem_rd: 1'b0, res: ffpa_pkg::RES_LOAD},
    3: '{cond: ffpa_pkg::C_GOTO, target: ffpa_pkg::S_SCAN_RD, take: 1'b0,
         ptr_clr: 1'b1, ptr_inc: 1'b0, mem_rd: 1'b0, res: ffpa_pkg::RES_NONE},
    4: '{cond: ffpa_pkg::C_WAIT_OUT, target: ffpa_pkg::S_IDLE, take: 1'b0,
         ptr_clr: 1'b0, ptr_inc: 1'b0, mem_rd: 1'b0, res: ffpa_pkg::RES_FREE},
    5: '{cond: ffpa_pkg::C_WAIT_OUT, target: ffpa_pkg::S_IDLE, take: 1'b0,
         ptr_clr: 1'b0, ptr_inc: 1'b0, mem_rd: 1'b0, res: ffpa_pkg::RES_OK},
    6: '{cond: ffpa_pkg::C_PTR_END, target: ffpa_pkg::S_NOFIT, take: 1'b0,
         ptr_clr: 1'b0, ptr_inc: 1'b0, mem_rd: 1'b1, res: ffpa_pkg::RES_NONE},
    7: '{cond: ffpa_pkg::C_MISS, target: ffpa_pkg::S_SCAN_RD, take: 1'b0,
         ptr_clr: 1'b0, ptr_inc: 1'b1, mem_rd: 1'b0, res: ffpa_pkg::RES_NONE},
    8: '{cond: ffpa_pkg::C_WAIT_OUT, target: ffpa_pkg::S_IDLE, take: 1'b0,
         ptr_clr: 1'b0, ptr_inc: 1'b0, mem_rd: 1'b0, res: ffpa_pkg::RES_GRANT},
    9: '{cond: ffpa_pkg::C_WAIT_OUT, target: ffpa_pkg::S_IDLE, take: 1'b0,
         ptr_clr: 1'b0, ptr_inc: 1'b0, mem_rd: 1'b0, res: ffpa_pkg::RES_NOFIT},
    default: '{cond: ffpa_pkg::C_GOTO, target: ffpa_pkg::S_IDLE, take: 1'b0,
         ptr_clr: 1'b0, ptr_inc: 1'b0, mem_rd: 1'b0, res: ffpa_pkg::RES_NONE}
  };

  assign cw = ROM[upc];

endmodule

// ===== hw/rtl/ffpa_sequencer.sv =====
// Step counter and jump logic of the allocator microprogram.
module ffpa_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  ffpa_pkg::cw_t    cw,
  input  ffpa_pkg::flags_t flags,
  output ffpa_pkg::upc_t   upc
);

  ffpa_pkg::upc_t upc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ffpa_pkg::S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  always_comb begin
    unique case (cw.cond)
      ffpa_pkg::C_NEXT:     upc_next = upc + 4'd1;
      ffpa_pkg::C_GOTO:     upc_next = cw.target;
      ffpa_pkg::C_WAIT_IN:  upc_next = flags.in_fire ? cw.target : upc;
      ffpa_pkg::C_DISPATCH: upc_next = cw.target + {2'b00, flags.func};
      ffpa_pkg::C_PTR_END:  upc_next = flags.ptr_end ? cw.target : upc + 4'd1;
      ffpa_pkg::C_MISS:     upc_next = flags.miss ? cw.target : upc + 4'd1;
      ffpa_pkg::C_WAIT_OUT: upc_next = flags.out_free ? cw.target : upc;
      default:              upc_next = ffpa_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/ffpa_datapath.sv =====
// Partition table, busy bits, scan pointer and result register.
module ffpa_datapath #(
  parameter int NUM_PARTS = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  ffpa_pkg::cw_t    cw,
  output ffpa_pkg::flags_t flags,
  input  logic             cfg_wr_en,
  input  logic [4:0]       cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       func,
  input  logic [3:0]       entry_index,
  input  logic [31:0]      req_size,
  input  logic [31:0]      load_start,
  input  logic [15:0]      load_label,
  input  logic             load_busy,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       status,
  output logic [3:0]       grant_index,
  output logic [31:0]      grant_start,
  output logic [15:0]      grant_label
);

  localparam int IW = $clog2(NUM_PARTS);
  localparam int CW = $clog2(NUM_PARTS + 1);
  localparam int SW = (ADDR_BITS < 32) ? ADDR_BITS : 32;

  logic [31:0]    mem_size  [NUM_PARTS];
  logic [SW-1:0]  mem_start [NUM_PARTS];
  logic [15:0]    mem_label [NUM_PARTS];
  logic [NUM_PARTS-1:0] busy;

  logic [4:0]     parts_in_use;
  logic [1:0]     func_r;
  logic [3:0]     idx_r;
  logic [31:0]    size_r;
  logic [SW-1:0]  start_r;
  logic [15:0]    label_r;
  logic           lbusy_r;
  logic [CW-1:0]  ptr;
  logic [31:0]    rd_size;
  logic [SW-1:0]  rd_start;
  logic [15:0]    rd_label;

  logic [CW-1:0]  n_act;
  logic           in_fire;
  logic           out_free;
  logic           fire;
  logic           load_ok;
  logic           free_range;
  logic           free_idle;
  logic           miss;
  logic [1:0]     status_next;
  logic           grant;

  assign in_stall = !cw.take;
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign fire     = (cw.res != ffpa_pkg::RES_NONE) && out_free;

  assign n_act = (32'(parts_in_use) > NUM_PARTS) ? CW'(NUM_PARTS) : CW'(parts_in_use);
  assign load_ok    = 32'(idx_r) < NUM_PARTS;
  assign free_range = 32'(idx_r) >= 32'(n_act);
  assign free_idle  = !busy[IW'(idx_r)];
  assign miss = busy[ptr[IW-1:0]] || (size_r > rd_size);

  assign flags = '{in_fire: in_fire, out_free: out_free, ptr_end: ptr >= n_act,
                   miss: miss, func: func_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      parts_in_use <= '0;
    end else if (cfg_wr_en) begin
      parts_in_use <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r  <= func;
      idx_r   <= entry_index;
      size_r  <= req_size;
      start_r <= load_start[SW-1:0];
      label_r <= load_label;
      lbusy_r <= load_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.ptr_clr) begin
      ptr <= '0;
    end else if (cw.ptr_inc && miss) begin
      ptr <= ptr + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fire && cw.res == ffpa_pkg::RES_LOAD && load_ok) begin
      mem_size[IW'(idx_r)]  <= size_r;
      mem_start[IW'(idx_r)] <= start_r;
      mem_label[IW'(idx_r)] <= label_r;
    end
    if (cw.mem_rd) begin
      rd_size  <= mem_size[ptr[IW-1:0]];
      rd_start <= mem_start[ptr[IW-1:0]];
      rd_label <= mem_label[ptr[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (fire) begin
      if (cw.res == ffpa_pkg::RES_LOAD && load_ok) begin
        busy[IW'(idx_r)] <= lbusy_r;
      end else if (cw.res == ffpa_pkg::RES_FREE && !free_range && !free_idle) begin
        busy[IW'(idx_r)] <= 1'b0;
      end else if (cw.res == ffpa_pkg::RES_GRANT) begin
        busy[ptr[IW-1:0]] <= 1'b1;
      end
    end
  end

  always_comb begin
    grant = 1'b0;
    case (cw.res)
      ffpa_pkg::RES_LOAD:  status_next = load_ok ? ffpa_pkg::ST_OK : ffpa_pkg::ST_RANGE;
      ffpa_pkg::RES_FREE: begin
        if (free_range) begin
          status_next = ffpa_pkg::ST_RANGE;
        end else if (free_idle) begin
          status_next = ffpa_pkg::ST_FREE;
        end else begin
          status_next = ffpa_pkg::ST_OK;
        end
      end
      ffpa_pkg::RES_NOFIT: status_next = ffpa_pkg::ST_NOFIT;
      ffpa_pkg::RES_GRANT: begin
        status_next = ffpa_pkg::ST_OK;
        grant = 1'b1;
      end
      default:             status_next = ffpa_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status      <= status_next;
      grant_index <= grant ? 4'(ptr) : 4'd0;
      grant_start <= grant ? 32'(rd_start) : 32'd0;
      grant_label <= grant ? rd_label : 16'd0;
    end
  end

endmodule

// ===== hw/rtl/first_fit_partition_allocator_unit.sv =====
// Top level of the first-fit fixed-partition allocator.
//
//   channel  direction  handshake            fields
//   cfg      in         cfg_wr_en            cfg_wr_data (parts_in_use)
//   in       in         in_valid / in_stall  func entry_index req_size load_start
//                                            load_label load_busy
//   out      out        out_valid/out_stall  status grant_index grant_start grant_label
//
// One item at a time. Load, free and no-op go from accept through dispatch to
// their result step. Allocate clears the scan pointer, then loops over the
// entries in use until one fits (grant) or none is left (no fit): each entry costs a
// registered table read and a compare step of the microprogram loop.
// Reset is synchronous; it clears busy bits, parts_in_use, out_valid and the sequencer.
// The result register lets the next item be accepted while a result waits;
// a result step holds while out_stall keeps the register full.
module first_fit_partition_allocator_unit #(
  parameter int NUM_PARTS = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [3:0]  entry_index,
  input  logic [31:0] req_size,
  input  logic [31:0] load_start,
  input  logic [15:0] load_label,
  input  logic        load_busy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [3:0]  grant_index,
  output logic [31:0] grant_start,
  output logic [15:0] grant_label
);

  ffpa_pkg::upc_t   upc;
  ffpa_pkg::cw_t    cw;
  ffpa_pkg::flags_t flags;

  ffpa_ucode_rom u_rom (
    .upc (upc),
    .cw  (cw)
  );

  ffpa_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .cw    (cw),
    .flags (flags),
    .upc   (upc)
  );

  ffpa_datapath #(
    .NUM_PARTS (NUM_PARTS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cw          (cw),
    .flags       (flags),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .entry_index (entry_index),
    .req_size    (req_size),
    .load_start  (load_start),
    .load_label  (load_label),
    .load_busy   (load_busy),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .grant_index (grant_index),
    .grant_start (grant_start),
    .grant_label (grant_label)
  );

endmodule
